### sv/polyline_stroke_extruder_core_macros.svh
// ----------------------------------------------------------------------------
// polyline_stroke_extruder_core_macros.svh
// Assertion macros shared by the stroke extruder RTL.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_STROKE_EXTRUDER_CORE_MACROS_SVH
`define POLYLINE_STROKE_EXTRUDER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pse assertion failed");
// next-cycle implication
`define PSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pse assertion failed");
`else
`define PSE_ASSERT_NOW(lbl, ante, cons)
`define PSE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### sv/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Widths, register indexes and shared types of the stroke extruder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pse_pkg;

  localparam int COORD_BITS      = 16;
  localparam int WIDTH_FRAC_BITS = 8;

  localparam int HW_W      = 16;  // half width, unsigned
  localparam int COLOR_W   = 32;
  localparam int OFF_W     = HW_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [HW_W-1:0] HW_MIN = HW_W'(1) << (WIDTH_FRAC_BITS - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR      = CFG_IDX_W'(1);

  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_JOIN    = 1'b1;

  // |dx|, |dy|
  localparam int MAG_W  = COORD_BITS + 1;
  // dx^2 + dy^2
  localparam int SQ_RAW_W = 2 * MAG_W;
  // sum of squares scaled by 2^(2F), root operand
  localparam int SQ_W   = SQ_RAW_W + 2 * WIDTH_FRAC_BITS;
  localparam int LEN_W  = SQ_W / 2;
  // |d| * half_width * 2^F
  localparam int NP_W   = MAG_W + HW_W;
  localparam int NUM_W  = NP_W + WIDTH_FRAC_BITS;
  // quotient never exceeds half_width
  localparam int QB     = HW_W;
  localparam int DSH_W  = LEN_W + QB - 1;

  localparam int ALU_W0 = (SQ_W > NUM_W) ? SQ_W : NUM_W;
  localparam int ALU_W  = (ALU_W0 > DSH_W) ? ALU_W0 : DSH_W;

  localparam int MB_W   = (MAG_W > HW_W) ? MAG_W : HW_W;
  localparam int PROD_W = MAG_W + MB_W;

  localparam int SQ_ITER = LEN_W;
  localparam int CNT_MAX = (SQ_ITER > QB) ? SQ_ITER : QB;
  localparam int CNT_W   = $clog2(CNT_MAX);

  typedef struct packed {
    logic             ge;
    logic [ALU_W-1:0] diff;
  } csub_res_t;

endpackage

### sv/pse_csub.sv
// ----------------------------------------------------------------------------
// pse_csub
// Shared compare-subtract unit for the root and divide iterations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pse_csub (
  input  logic [pse_pkg::ALU_W-1:0] a,
  input  logic [pse_pkg::ALU_W-1:0] b,
  output pse_pkg::csub_res_t        res
);
  import pse_pkg::*;

  assign res.diff = a - b;
  assign res.ge   = (a >= b);

endmodule

### sv/polyline_stroke_extruder_core.sv
// ----------------------------------------------------------------------------
// polyline_stroke_extruder_core
// Turns a stream of polyline points into segment and square join quads.
// ----------------------------------------------------------------------------
// Points arrive one per transfer. The first point of a path (path_start, or
// any point right after reset) only loads the previous-point register; it is
// absorbed at its transfer edge and the next point can follow on the next
// cycle. Every later point emits a segment quad (skipped when the segment has
// zero length), then a join at the first point if this is the second point of
// the path, then a join at this point, which carries last_quad. The segment
// offset is the normal (-dy, dx) scaled by half_width, with the length
// floor(sqrt((dx^2+dy^2) * 2^2F)). One compare-subtract unit does all the
// work: the square root yields one bit per cycle and each of the two offset
// divisions one quotient bit per cycle, with one multiplier step ahead of
// each. The input is stalled while a point is in work; the next point is
// taken the cycle after the last quad is loaded, even while that quad still
// waits on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polyline_stroke_extruder_core_macros.svh"

module polyline_stroke_extruder_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pse_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0]       cfg_data,
  // points
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 path_start,
  input  logic signed [pse_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [pse_pkg::COORD_BITS-1:0] point_y,
  // quads
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 quad_kind,
  output logic signed [pse_pkg::COORD_BITS-1:0] start_x,
  output logic signed [pse_pkg::COORD_BITS-1:0] start_y,
  output logic signed [pse_pkg::COORD_BITS-1:0] end_x,
  output logic signed [pse_pkg::COORD_BITS-1:0] end_y,
  output logic signed [pse_pkg::OFF_W-1:0]      offset_x,
  output logic signed [pse_pkg::OFF_W-1:0]      offset_y,
  output logic [pse_pkg::COLOR_W-1:0]          quad_color,
  output logic                                 last_quad
);
  import pse_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQRT,
    ST_NUM_X,
    ST_DIV_X,
    ST_NUM_Y,
    ST_DIV_Y,
    ST_EMIT_SEG,
    ST_EMIT_J0,
    ST_EMIT_J1
  } state_t;

  state_t state;

  // configuration registers
  logic [HW_W-1:0]    half_width;
  logic [COLOR_W-1:0] color_rgba;

  // path state
  logic signed [COORD_BITS-1:0] prev_x, prev_y;
  logic [1:0]                   points_seen;

  // current point
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic                         ps_one;     // second point of its path
  logic [MAG_W-1:0]             adx, ady;
  logic                         dx_neg, dy_pos;

  // iteration registers
  logic [ALU_W-1:0]  acc;    // radicand / remainder
  logic [ALU_W-1:0]  opr;    // root / shifted divisor
  logic [ALU_W-1:0]  bitr;   // root trial bit
  logic [LEN_W-1:0]  seg_len;
  logic [QB-1:0]     qr;
  logic [CNT_W-1:0]  cnt;
  logic signed [OFF_W-1:0] off_x, off_y;

  // ------------------------------------------------------------------
  // handshakes
  // ------------------------------------------------------------------
  logic in_xfer, out_free, first_pt, emit_now;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign first_pt  = path_start || (points_seen == 2'd0);
  // a quad is loaded into the output register this cycle
  assign emit_now  = out_free &&
                     ((state == ST_EMIT_SEG) || (state == ST_EMIT_J0) || (state == ST_EMIT_J1));

  // segment delta at accept
  logic signed [MAG_W-1:0] dx, dy;
  assign dx = MAG_W'(point_x) - MAG_W'(prev_x);
  assign dy = MAG_W'(point_y) - MAG_W'(prev_y);

  // ------------------------------------------------------------------
  // shared multiplier: squares, then |d| * half_width
  // ------------------------------------------------------------------
  logic [MAG_W-1:0]  mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod;

  always_comb begin
    mul_a = adx;
    mul_b = MB_W'(adx);
    case (state)
      ST_SQ_Y: begin
        mul_a = ady;
        mul_b = MB_W'(ady);
      end
      ST_NUM_X: begin
        mul_a = ady;
        mul_b = MB_W'(half_width);
      end
      ST_NUM_Y: begin
        mul_a = adx;
        mul_b = MB_W'(half_width);
      end
      default: begin
        mul_a = adx;
        mul_b = MB_W'(adx);
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  logic [SQ_RAW_W-1:0] sq_sum;
  assign sq_sum = acc[SQ_RAW_W-1:0] + prod[SQ_RAW_W-1:0];

  // ------------------------------------------------------------------
  // shared compare-subtract
  // ------------------------------------------------------------------
  logic [ALU_W-1:0] csub_b;
  csub_res_t        cs;

  assign csub_b = (state == ST_SQRT) ? (opr + bitr) : opr;

  pse_csub u_csub (
    .a   (acc),
    .b   (csub_b),
    .res (cs)
  );

  // final quotient bit lands with the last step
  logic [QB-1:0]          q_fin;
  logic signed [OFF_W-1:0] q_pos;
  assign q_fin = {qr[QB-2:0], cs.ge};
  assign q_pos = $signed({1'b0, q_fin});

  logic last_step_sqrt, last_step_div;
  assign last_step_sqrt = (cnt == CNT_W'(SQ_ITER - 1));
  assign last_step_div  = (cnt == CNT_W'(QB - 1));

  logic signed [OFF_W-1:0] hw_off;
  assign hw_off = $signed({1'b0, half_width});

  state_t after_seg;
  assign after_seg = ps_one ? ST_EMIT_J0 : ST_EMIT_J1;

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      half_width  <= HW_MIN;
      color_rgba  <= '0;
      prev_x      <= '0;
      prev_y      <= '0;
      points_seen <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_HALF_WIDTH: half_width <= (cfg_data[HW_W-1:0] < HW_MIN) ? HW_MIN
                                                                      : cfg_data[HW_W-1:0];
          CFG_COLOR:      color_rgba <= cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end

      // emit states reload the register themselves
      if (out_valid && !out_stall && !emit_now) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (first_pt) begin
              prev_x      <= point_x;
              prev_y      <= point_y;
              points_seen <= 2'd1;
            end else begin
              cur_x  <= point_x;
              cur_y  <= point_y;
              ps_one <= (points_seen == 2'd1);
              adx    <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
              ady    <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
              dx_neg <= dx[MAG_W-1];
              dy_pos <= !dy[MAG_W-1] && (dy != '0);
              state  <= ST_SQ_X;
            end
          end
        end

        ST_SQ_X: begin
          acc   <= ALU_W'(prod[SQ_RAW_W-1:0]);
          state <= ST_SQ_Y;
        end

        ST_SQ_Y: begin
          if (sq_sum == '0) begin
            state <= after_seg;
          end else begin
            acc   <= ALU_W'({sq_sum, {(2*WIDTH_FRAC_BITS){1'b0}}});
            opr   <= '0;
            bitr  <= ALU_W'(1) << (SQ_W - 2);
            cnt   <= '0;
            state <= ST_SQRT;
          end
        end

        // bitwise root: one result bit per cycle
        ST_SQRT: begin
          if (cs.ge) begin
            acc <= cs.diff;
            opr <= (opr >> 1) + bitr;
          end else begin
            opr <= opr >> 1;
          end
          bitr <= bitr >> 2;
          cnt  <= cnt + CNT_W'(1);
          if (last_step_sqrt) begin
            state <= ST_NUM_X;
          end
        end

        ST_NUM_X: begin
          seg_len <= opr[LEN_W-1:0];
          acc     <= ALU_W'({prod[NP_W-1:0], {WIDTH_FRAC_BITS{1'b0}}});
          opr     <= ALU_W'({opr[LEN_W-1:0], {(QB-1){1'b0}}});
          cnt     <= '0;
          state   <= ST_DIV_X;
        end

        // restoring divide: one quotient bit per cycle
        ST_DIV_X: begin
          if (cs.ge) begin
            acc <= cs.diff;
          end
          qr  <= q_fin;
          opr <= opr >> 1;
          cnt <= cnt + CNT_W'(1);
          if (last_step_div) begin
            off_x <= dy_pos ? -q_pos : q_pos;
            state <= ST_NUM_Y;
          end
        end

        ST_NUM_Y: begin
          acc   <= ALU_W'({prod[NP_W-1:0], {WIDTH_FRAC_BITS{1'b0}}});
          opr   <= ALU_W'({seg_len, {(QB-1){1'b0}}});
          cnt   <= '0;
          state <= ST_DIV_Y;
        end

        ST_DIV_Y: begin
          if (cs.ge) begin
            acc <= cs.diff;
          end
          qr  <= q_fin;
          opr <= opr >> 1;
          cnt <= cnt + CNT_W'(1);
          if (last_step_div) begin
            off_y <= dx_neg ? -q_pos : q_pos;
            state <= ST_EMIT_SEG;
          end
        end

        ST_EMIT_SEG: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            quad_kind  <= KIND_SEGMENT;
            start_x    <= prev_x;
            start_y    <= prev_y;
            end_x      <= cur_x;
            end_y      <= cur_y;
            offset_x   <= off_x;
            offset_y   <= off_y;
            quad_color <= color_rgba;
            last_quad  <= 1'b0;
            state      <= after_seg;
          end
        end

        ST_EMIT_J0: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            quad_kind  <= KIND_JOIN;
            start_x    <= prev_x;
            start_y    <= prev_y;
            end_x      <= prev_x;
            end_y      <= prev_y;
            offset_x   <= hw_off;
            offset_y   <= hw_off;
            quad_color <= color_rgba;
            last_quad  <= 1'b0;
            state      <= ST_EMIT_J1;
          end
        end

        ST_EMIT_J1: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            quad_kind   <= KIND_JOIN;
            start_x     <= cur_x;
            start_y     <= cur_y;
            end_x       <= cur_x;
            end_y       <= cur_y;
            offset_x    <= hw_off;
            offset_y    <= hw_off;
            quad_color  <= color_rgba;
            last_quad   <= 1'b1;
            prev_x      <= cur_x;
            prev_y      <= cur_y;
            points_seen <= 2'd2;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  logic join_ok, off_ok;
  assign join_ok = (start_x == end_x) && (start_y == end_y) && (offset_x == offset_y);
  assign off_ok  = (off_x <= hw_off) && (off_x >= -hw_off) &&
                   (off_y <= hw_off) && (off_y >= -hw_off);

  // a join sits on one point with equal offsets
  `PSE_ASSERT_NOW(a_join_shape, out_valid && (quad_kind == KIND_JOIN), join_ok)
  // only the closing join of a point is flagged last
  `PSE_ASSERT_NOW(a_last_is_join, out_valid && last_quad, quad_kind == KIND_JOIN)
  // the normal never exceeds the half width in either axis
  `PSE_ASSERT_NOW(a_off_bound, state == ST_EMIT_SEG, off_ok)
  // a path's first point is absorbed without work
  `PSE_ASSERT_NEXT(a_first_idle, in_xfer && first_pt, (state == ST_IDLE) && (points_seen == 2'd1))

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for polyline_stroke_extruder_core: drives polyline
// points and register writes, predicts every stroke quad, and checks each
// output quad field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import pse_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 7;
  // index with no register behind it; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
  // a first point makes no quad and leaves the core idle; this settle time
  // covers any work left over
  localparam int SETTLE_CYCLES    = 80;
  localparam int TAIL_CYCLES      = 100;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int HOLD_CYCLES      = 400;
  localparam int RANDOM_PER_PHASE = 58;
  localparam int PRINT_CAP        = 40;
  localparam longint OFF_SAT      = 65535;
  localparam int TIMEOUT_NS       = 2_000_000;

  typedef struct {
    logic                         kind;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic signed [OFF_W-1:0]      ox;
    logic signed [OFF_W-1:0]      oy;
    logic [COLOR_W-1:0]           color;
    logic                         last;
  } quad_t;

  // Stroke predictor: tracks the open path and the register copies, and
  // holds the quads still owed by the core.
  class stroke_tracker;
    logic [HW_W-1:0]              half_width;
    logic [COLOR_W-1:0]           color;
    logic signed [COORD_BITS-1:0] prev_x;
    logic signed [COORD_BITS-1:0] prev_y;
    int                           points_seen;
    quad_t                        pending_quads[$];
    int                           errors;
    int                           quads_checked;

    function new();
      half_width    = HW_MIN;
      color         = '0;
      prev_x        = '0;
      prev_y        = '0;
      points_seen   = 0;
      errors        = 0;
      quads_checked = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH: %s", what);
    endtask

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_HALF_WIDTH) begin
        half_width = data[HW_W-1:0];
        if (half_width < HW_MIN) half_width = HW_MIN;
      end else if (idx == CFG_COLOR) begin
        color = data;
      end
    endfunction

    // floor(sqrt(n)), one result bit at a time from the top
    function longint unsigned floor_root(longint unsigned n);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    // trunc(num * half_width * 2^F / len), clamped to the offset range
    function logic signed [OFF_W-1:0] extrude(longint num, longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      longint          r;
      mag = (num < 0) ? -num : num;
      q = ((mag * half_width) << WIDTH_FRAC_BITS) / len;
      if (q > OFF_SAT) q = OFF_SAT;
      r = (num < 0) ? -longint'(q) : longint'(q);
      return r[OFF_W-1:0];
    endfunction

    function void push_quad(logic kind,
                            logic signed [COORD_BITS-1:0] sx, logic signed [COORD_BITS-1:0] sy,
                            logic signed [COORD_BITS-1:0] ex, logic signed [COORD_BITS-1:0] ey,
                            logic signed [OFF_W-1:0] ox, logic signed [OFF_W-1:0] oy,
                            logic last);
      quad_t q;
      q.kind  = kind;
      q.sx    = sx;
      q.sy    = sy;
      q.ex    = ex;
      q.ey    = ey;
      q.ox    = ox;
      q.oy    = oy;
      q.color = color;
      q.last  = last;
      pending_quads.insert(pending_quads.size(), q);
    endfunction

    // one point transfer: works out the quads it causes
    function void take_point(logic start, logic signed [COORD_BITS-1:0] x,
                             logic signed [COORD_BITS-1:0] y);
      longint                  dx;
      longint                  dy;
      longint unsigned         adx;
      longint unsigned         ady;
      longint unsigned         sq;
      longint unsigned         len;
      logic signed [OFF_W-1:0] hw_off;
      // path start, or any point while no path is open, only loads prev
      if (start || points_seen == 0) begin
        prev_x      = x;
        prev_y      = y;
        points_seen = 1;
        return;
      end
      hw_off = {1'b0, half_width};
      dx  = longint'(x) - longint'(prev_x);
      dy  = longint'(y) - longint'(prev_y);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      sq  = adx * adx + ady * ady;
      // zero-length segment: joins only
      if (sq != 0) begin
        len = floor_root(sq << (2 * WIDTH_FRAC_BITS));
        if (len == 0) len = 1;
        push_quad(KIND_SEGMENT, prev_x, prev_y, x, y, extrude(-dy, len), extrude(dx, len),
                  1'b0);
      end
      // second point of a path also closes off the first point
      if (points_seen == 1)
        push_quad(KIND_JOIN, prev_x, prev_y, prev_x, prev_y, hw_off, hw_off, 1'b0);
      push_quad(KIND_JOIN, x, y, x, y, hw_off, hw_off, 1'b1);
      prev_x      = x;
      prev_y      = y;
      points_seen = 2;
    endfunction

    task check_field(string name, longint got, longint want);
      if (got != want)
        report($sformatf("quad %0d %s got %0d want %0d", quads_checked, name, got, want));
    endtask

    task match_quad(quad_t got);
      quad_t want;
      if (pending_quads.size() == 0) begin
        report($sformatf("quad %0d arrived with nothing expected", quads_checked));
      end else begin
        want = pending_quads.pop_front();
        check_field("quad_kind", got.kind, want.kind);
        check_field("start_x", got.sx, want.sx);
        check_field("start_y", got.sy, want.sy);
        check_field("end_x", got.ex, want.ex);
        check_field("end_y", got.ey, want.ey);
        check_field("offset_x", got.ox, want.ox);
        check_field("offset_y", got.oy, want.oy);
        check_field("quad_color", got.color, want.color);
        check_field("last_quad", got.last, want.last);
      end
      quads_checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         path_start = 1'b0;
  logic signed [COORD_BITS-1:0] point_x = '0;
  logic signed [COORD_BITS-1:0] point_y = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         quad_kind;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [OFF_W-1:0]      offset_x;
  logic signed [OFF_W-1:0]      offset_y;
  logic [COLOR_W-1:0]           quad_color;
  logic                         last_quad;

  // idle rates in percent per cycle; hold_left forces a long output stall
  int send_idle_pct = 34;
  int recv_idle_pct = 61;
  int hold_left     = 0;
  int points_sent   = 0;

  stroke_tracker strokes = new();

  always #(CLK_PERIOD / 2) clk = ~clk;

  polyline_stroke_extruder_core uut (.*);

  // --------------------------------------------------------------------------
  // monitor: every transfer is sampled at the edge where it happens, before
  // any of this edge's nonblocking updates land
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    quad_t seen_quad;
    if (!rst) begin
      if (in_valid && !in_stall) strokes.take_point(path_start, point_x, point_y);
      if (out_valid && !out_stall) begin
        seen_quad.kind  = quad_kind;
        seen_quad.sx    = start_x;
        seen_quad.sy    = start_y;
        seen_quad.ex    = end_x;
        seen_quad.ey    = end_y;
        seen_quad.ox    = offset_x;
        seen_quad.oy    = offset_y;
        seen_quad.color = quad_color;
        seen_quad.last  = last_quad;
        strokes.match_quad(seen_quad);
      end
    end
  end

  // --------------------------------------------------------------------------
  // quad receiver: random stall, or a long hold-off counted down here so the
  // core backs up into its input while points keep being offered
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // point sender
  // --------------------------------------------------------------------------
  // offers one point, with a random gap ahead of it; returns at the edge of
  // the transfer with valid still high, so back-to-back points never drop it
  task automatic offer_point(input logic start, input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    path_start <= start;
    point_x    <= x;
    point_y    <= y;
    do @(posedge clk); while (in_stall);
    points_sent++;
  endtask

  // drops valid and waits until every owed quad has come, then lets the core
  // finish any first-point work that owes nothing
  task automatic quiesce(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (strokes.pending_quads.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes; caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    strokes.set_config(idx, data);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] hw, input logic [CFG_DATA_W-1:0] rgba);
    write_reg(CFG_HALF_WIDTH, hw);
    write_reg(CFG_COLOR, rgba);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed polylines: a start point then 1..5 more with a mix of
  // repeated points, short, medium, axis-aligned and far steps. The rest is
  // stray points with random path_start and jumps that continue an open path.
  task automatic random_polyline();
    int                           roll;
    int                           pick;
    int                           count;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    roll = $urandom_range(99);
    x    = COORD_BITS'($urandom);
    y    = COORD_BITS'($urandom);
    if (roll < 8) begin
      offer_point(1'($urandom_range(1)), x, y);
    end else if (roll < 14) begin
      offer_point(1'b0, x, y);
    end else begin
      offer_point(1'b1, x, y);
      count = $urandom_range(5, 1);
      repeat (count) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          // same point again: zero-length segment
        end else if (pick <= 3) begin
          x = x + COORD_BITS'($urandom_range(6)) - COORD_BITS'(3);
          y = y + COORD_BITS'($urandom_range(6)) - COORD_BITS'(3);
        end else if (pick <= 6) begin
          x = x + COORD_BITS'($urandom_range(600)) - COORD_BITS'(300);
          y = y + COORD_BITS'($urandom_range(600)) - COORD_BITS'(300);
        end else if (pick == 7) begin
          x = x + COORD_BITS'($urandom_range(600)) - COORD_BITS'(300);
        end else begin
          x = COORD_BITS'($urandom);
          y = COORD_BITS'($urandom);
        end
        offer_point(1'b0, x, y);
      end
    end
  endtask

  task automatic random_points(input int n);
    int goal;
    goal = points_sent + n;
    while (points_sent < goal) random_polyline();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset register values (half width 0.5 px, color 0).
    offer_point(1'b0, 16'sd100, 16'sd200);      // no path_start after reset: opens a path
    offer_point(1'b0, 16'sd103, 16'sd204);      // 3-4-5 segment, both joins
    offer_point(1'b0, 16'sd103, 16'sd204);      // repeated point: join only
    offer_point(1'b1, -16'sd32768, -16'sd32768);
    offer_point(1'b0, 16'sd32767, 16'sd32767);  // longest diagonal
    offer_point(1'b0, -16'sd32768, 16'sd32767); // longest horizontal, negative
    offer_point(1'b0, -16'sd32768, -16'sd32768); // longest vertical, negative
    offer_point(1'b1, 16'sd5, 16'sd5);          // lone point
    offer_point(1'b1, 16'sd7, -16'sd9);         // another lone point, same spot next
    offer_point(1'b1, 16'sd7, -16'sd9);
    offer_point(1'b0, 16'sd7, -16'sd9);         // zero-length second point: two joins
    offer_point(1'b0, 16'sd8, -16'sd9);         // unit steps
    offer_point(1'b0, 16'sd8, -16'sd8);
    offer_point(1'b0, 16'sd7, -16'sd10);
    offer_point(1'b1, 16'sd0, 16'sd0);
    offer_point(1'b0, -16'sd1, -16'sd1);
    offer_point(1'b0, 16'sd32767, -16'sd32768);
    offer_point(1'b0, 16'sd0, 16'sd0);
    offer_point(1'b1, 16'sh5555, 16'shAAAA);     // alternating bit patterns
    offer_point(1'b0, 16'shAAAA, 16'sh5555);
    quiesce(SETTLE_CYCLES);

    // widest stroke, all-ones color
    configure(32'h0000_FFFF, 32'hFFFF_FFFF);
    random_points(RANDOM_PER_PHASE);
    quiesce(SETTLE_CYCLES);

    // sender now idles more than the receiver; width 0 is raised to 0.5 px
    send_idle_pct = 61;
    recv_idle_pct = 34;
    configure(32'h0000_0000, 32'h80C0_10FE);
    random_points(RANDOM_PER_PHASE);
    quiesce(SETTLE_CYCLES);

    // upper data bits are dropped for the width; long receiver hold-off
    configure(32'hABCD_0100, $urandom);
    random_points(15);
    hold_left = HOLD_CYCLES;
    random_points(RANDOM_PER_PHASE - 15);
    quiesce(SETTLE_CYCLES);

    // no idling; a write to an unused index must not disturb anything
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_SPARE, $urandom);
    configure(CFG_DATA_W'($urandom_range(65535, 128)), $urandom);
    random_points(29);
    quiesce(0);                                 // sender waits for a full drain
    random_points(RANDOM_PER_PHASE - 29);
    quiesce(SETTLE_CYCLES);

    // narrowest legal width written exactly
    configure(32'h0000_0080, 32'h0000_0001);
    random_points(RANDOM_PER_PHASE);

    // drain, then give the core time to show any quad nobody asked for
    in_valid <= 1'b0;
    for (waited = 0; waited < DRAIN_LIMIT && strokes.pending_quads.size() != 0; waited++)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    while (strokes.pending_quads.size() != 0) begin
      void'(strokes.pending_quads.pop_front());
      strokes.report("expected quad never came");
    end

    if (strokes.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top: errors");
    $finish;
  end

endmodule
